FILE: src/vc1_start_code_split_unescape_macros.svh
// Assertion helpers used by the file that checks this block.
`ifndef VC1_START_CODE_SPLIT_UNESCAPE_MACROS_SVH
`define VC1_START_CODE_SPLIT_UNESCAPE_MACROS_SVH

// Same-cycle implication, checked at each rising edge out of reset.
`define VC1SCU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at each rising edge out of reset.
`define VC1SCU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/vc1scu_pkg.sv
`timescale 1ns / 1ps

package vc1scu_pkg;

	localparam int unsigned WIN_DEPTH = 5;
	localparam int unsigned HOLD_BACK = 4;
	localparam int unsigned PRE_DEPTH = 3;
	localparam int unsigned FILL_W    = $clog2(WIN_DEPTH + 1);
	localparam int unsigned QDEPTH    = 2;

	localparam logic [7:0]  ESC_BYTE  = 8'h03;
	localparam logic [7:0]  ESC_LIMIT = 8'h04;
	localparam logic [7:0]  ZERO_BYTE = 8'h00;
	localparam logic [23:0] SC_PREFIX = 24'h000001;
	localparam logic [1:0]  POS_MAX   = 2'd2;
	localparam logic [1:0]  ZH_FULL   = 2'b11;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_buffer;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       code_flag;
		logic       last_of_item;
	} out_item_t;

	// Work for the back end from one input beat: decide the first n_ops bytes
	// of seq oldest first, then open a new code and/or close the buffer.
	typedef struct packed {
		logic [FILL_W-1:0]            n_ops;
		logic                         last_has_next;
		byte_t [WIN_DEPTH-1:0]        seq;
		logic                         new_code;
		byte_t                        code;
		logic                         eob;
	} work_t;

endpackage

FILE: src/vc1_start_code_split_unescape.sv
`timescale 1ns / 1ps
// VC-1 start code splitter and escape remover.
// Input channel: push/full with one raw byte per beat on item (in_byte plus
// end_of_buffer on the final byte of a buffer). Output channel: empty/pop with
// one result per beat on result: a payload byte with escape bytes removed, or
// a start code type with code_flag set; last_of_item marks the final result
// caused by one input beat. An input beat may cause zero to six results.
// Throughput: one input beat per cycle while each beat decides at most one
// byte, no code type waits and results are popped. The front end finds codes
// and builds a work entry per beat combinationally; a two-entry queue parts
// it from the back end, which makes the escape decisions one byte a cycle,
// kept or dropped, while results are popped, sends a waiting code type first
// and takes up even a beat that decides no byte. full rises only while the
// back end is busy, and each result is registered before it shows.
// Reset (arst_n low) empties the queue and the result register and starts a
// new buffer: bytes before the first start code are dropped.
// When pop stays low the result holds, the back end stalls, then the queue
// fills and full rises; no beat is lost.

`include "vc1_start_code_split_unescape_macros.svh"

module vc1_start_code_split_unescape (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  vc1scu_pkg::in_item_t  item,
	output logic                  empty,
	input  logic                  pop,
	output vc1scu_pkg::out_item_t result
);

	logic              accept;
	logic              q_full;
	logic              q_nonempty;
	logic              q_take;
	logic              back_busy;
	vc1scu_pkg::work_t front_entry;
	vc1scu_pkg::work_t head;

	// take a beat only when the queue has room for its work entry
	assign full   = q_full;
	assign accept = push && !q_full;

	vc1scu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.accept (accept),
		.entry  (front_entry)
	);

	vc1scu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept),
		.wr_data  (front_entry),
		.full     (q_full),
		.rd_en    (q_take),
		.rd_data  (head),
		.nonempty (q_nonempty)
	);

	vc1scu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (q_nonempty),
		.take       (q_take),
		.busy       (back_busy),
		.result     (result),
		.empty      (empty),
		.pop        (pop)
	);

	// queue can only fill up behind a busy back end
	`VC1SCU_ASSERT_IMPL(a_full_means_busy, clk, arst_n, q_full, back_busy, "queue full while back idle")
	// an idle back end picks up waiting work at once
	`VC1SCU_ASSERT_NEXT(a_idle_loads, clk, arst_n, !back_busy && q_nonempty, back_busy, "work left")
	// a code type is always followed by a payload byte of the same beat
	`VC1SCU_ASSERT_IMPL(a_marker_not_last, clk, arst_n, !empty && result.code_flag, !result.last_of_item, "marker last")

endmodule

FILE: src/vc1scu_front.sv
`timescale 1ns / 1ps

module vc1scu_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vc1scu_pkg::in_item_t item,
	input  logic                 accept,
	output vc1scu_pkg::work_t    entry
);

	localparam int unsigned FW = vc1scu_pkg::FILL_W;
	localparam int unsigned HB = vc1scu_pkg::HOLD_BACK;

	vc1scu_pkg::byte_t wl_q [HB];
	vc1scu_pkg::byte_t wl_d [HB];
	logic [23:0]       hist_q;
	logic [FW-1:0]     fill_q;
	logic [FW-1:0]     fill_d;
	logic              mseen_q;
	logic              mseen_d;
	logic              found;
	logic              shift;
	logic [FW-1:0]     lim;
	vc1scu_pkg::byte_t b;
	logic              eob;

	always_comb begin
		b     = item.in_byte;
		eob   = item.end_of_buffer;
		found = (fill_q >= FW'(vc1scu_pkg::PRE_DEPTH)) && (hist_q == vc1scu_pkg::SC_PREFIX);

		// raw bytes in arrival order, the incoming one right after the held ones
		for (int k = 0; k < int'(HB); k++) begin
			entry.seq[k] = (FW'(k) < fill_q) ? wl_q[k] : b;
		end
		entry.seq[vc1scu_pkg::WIN_DEPTH-1] = b;

		entry.n_ops         = '0;
		entry.last_has_next = 1'b0;
		priority if (!mseen_q) begin
			entry.n_ops = '0;
		end else if (found) begin
			entry.n_ops = (fill_q == FW'(HB)) ? FW'(1) : FW'(0);
		end else if (eob) begin
			entry.n_ops = fill_q + FW'(1);
		end else if (fill_q == FW'(HB)) begin
			entry.n_ops         = FW'(1);
			entry.last_has_next = 1'b1;
		end else begin
			entry.n_ops = '0;
		end
		entry.new_code = found;
		entry.code     = b;
		entry.eob      = eob;

		// append the byte, dropping the oldest when the window is at its limit
		lim   = mseen_q ? FW'(HB) : FW'(vc1scu_pkg::PRE_DEPTH);
		shift = (fill_q == lim);
		for (int k = 0; k < int'(HB) - 1; k++) begin
			if (shift) begin
				wl_d[k] = (FW'(k + 1) == lim) ? b : wl_q[k + 1];
			end else begin
				wl_d[k] = (FW'(k) == fill_q) ? b : wl_q[k];
			end
		end
		if (shift) begin
			wl_d[HB-1] = (lim == FW'(HB)) ? b : wl_q[HB-1];
		end else begin
			wl_d[HB-1] = (fill_q == FW'(HB - 1)) ? b : wl_q[HB-1];
		end

		priority if (eob || found) begin
			fill_d = '0;
		end else if (shift) begin
			fill_d = fill_q;
		end else begin
			fill_d = fill_q + FW'(1);
		end

		priority if (eob) begin
			mseen_d = 1'b0;
		end else if (found) begin
			mseen_d = 1'b1;
		end else begin
			mseen_d = mseen_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			mseen_q <= 1'b0;
		end else if (accept) begin
			fill_q  <= fill_d;
			mseen_q <= mseen_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wl_q   <= wl_d;
			hist_q <= {hist_q[15:0], b};
		end
	end

endmodule

FILE: src/vc1scu_queue.sv
`timescale 1ns / 1ps

module vc1scu_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  vc1scu_pkg::work_t wr_data,
	output logic              full,
	input  logic              rd_en,
	output vc1scu_pkg::work_t rd_data,
	output logic              nonempty
);

	localparam int unsigned DEPTH = vc1scu_pkg::QDEPTH;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW    = $clog2(DEPTH + 1);

	vc1scu_pkg::work_t mem [DEPTH];
	logic [AW-1:0]     wptr_q;
	logic [AW-1:0]     rptr_q;
	logic [CW-1:0]     cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign rd_data  = mem[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (rd_en) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			unique case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wptr_q] <= wr_data;
		end
	end

endmodule

FILE: src/vc1scu_back.sv
`timescale 1ns / 1ps

module vc1scu_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  vc1scu_pkg::work_t     head,
	input  logic                  head_valid,
	output logic                  take,
	output logic                  busy,
	output vc1scu_pkg::out_item_t result,
	output logic                  empty,
	input  logic                  pop
);

	localparam int unsigned FW = vc1scu_pkg::FILL_W;

	vc1scu_pkg::work_t     w_q;
	logic                  busy_q;
	logic [1:0]            zh_q;
	logic                  skip_q;
	logic [1:0]            pos_q;
	logic                  pend_v_q;
	vc1scu_pkg::byte_t     pend_code_q;
	logic                  ov_q;
	vc1scu_pkg::out_item_t res_q;
	vc1scu_pkg::out_item_t res_d;

	vc1scu_pkg::byte_t cur;
	vc1scu_pkg::byte_t nx;
	logic              has_next;
	logic              drop;
	logic              ops_left;
	logic              out_free;
	logic              do_marker;
	logic              do_decide;
	logic              finish;
	logic              emit;

	always_comb begin
		cur      = w_q.seq[0];
		nx       = w_q.seq[1];
		has_next = (w_q.n_ops > FW'(1)) || w_q.last_has_next;
		drop     = !skip_q && (cur == vc1scu_pkg::ESC_BYTE) && (pos_q == vc1scu_pkg::POS_MAX) &&
			(zh_q == vc1scu_pkg::ZH_FULL) && has_next && (nx < vc1scu_pkg::ESC_LIMIT);
		ops_left  = (w_q.n_ops != '0);
		out_free  = !ov_q || pop;
		// the code type goes out ahead of the first byte of its payload
		do_marker = busy_q && ops_left && pend_v_q && out_free;
		do_decide = busy_q && ops_left && !pend_v_q && (drop || out_free);
		finish    = busy_q && (!ops_left || (do_decide && (w_q.n_ops == FW'(1))));
		take      = head_valid && (!busy_q || finish);
		emit      = do_marker || (do_decide && !drop);
		if (pend_v_q) begin
			res_d.out_byte     = pend_code_q;
			res_d.code_flag    = 1'b1;
			res_d.last_of_item = 1'b0;
		end else begin
			res_d.out_byte     = cur;
			res_d.code_flag    = 1'b0;
			res_d.last_of_item = (w_q.n_ops == FW'(1));
		end
	end

	assign busy   = busy_q;
	assign empty  = !ov_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			ov_q     <= 1'b0;
			zh_q     <= '0;
			skip_q   <= 1'b0;
			pos_q    <= '0;
			pend_v_q <= 1'b0;
		end else begin
			if (emit) begin
				ov_q <= 1'b1;
			end else if (pop) begin
				ov_q <= 1'b0;
			end
			// restart the escape history for a new code or a new buffer
			if (finish && (w_q.new_code || w_q.eob)) begin
				pend_v_q <= w_q.new_code && !w_q.eob;
				zh_q     <= '0;
				skip_q   <= 1'b0;
				pos_q    <= '0;
			end else begin
				if (do_marker) begin
					pend_v_q <= 1'b0;
				end
				if (do_decide) begin
					skip_q <= drop;
					zh_q   <= {zh_q[0], cur == vc1scu_pkg::ZERO_BYTE};
					if (pos_q != vc1scu_pkg::POS_MAX) begin
						pos_q <= pos_q + 2'd1;
					end
				end
			end
			if (take) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_d;
		end
		if (finish && w_q.new_code) begin
			pend_code_q <= w_q.code;
		end
		if (take) begin
			w_q <= head;
		end else if (do_decide) begin
			w_q.seq   <= w_q.seq >> $bits(vc1scu_pkg::byte_t);
			w_q.n_ops <= w_q.n_ops - FW'(1);
		end
	end

endmodule
